[design/mpd_pkg.sv]
// ---------------------------------------------------------------------------
// mpd_pkg - mouse packet decoder package
// Packet format codes, field widths and the packed layout of a report.
// ---------------------------------------------------------------------------
package mpd_pkg;

   localparam int BYTE_W    = 8;
   localparam int FORMAT_W  = 2;
   localparam int INDEX_W   = 2;
   localparam int DELTA_W   = 9;
   localparam int WHEEL_W   = 8;
   localparam int POS_W     = 32;
   localparam int EXTRA_W   = 2;
   localparam int RSP_PAD_W = 7;

   // packet_format register codes; the unused code decodes as the wheel format
   localparam logic [FORMAT_W-1:0] FMT_STANDARD = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_WHEEL    = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_EXTENDED = 2'd2;
   localparam logic [FORMAT_W-1:0] FMT_RESET    = FMT_WHEEL;

   // byte positions within a packet
   localparam logic [INDEX_W-1:0] IDX_HEADER = 2'd0;
   localparam logic [INDEX_W-1:0] IDX_X      = 2'd1;
   localparam logic [INDEX_W-1:0] IDX_Y      = 2'd2;
   localparam logic [INDEX_W-1:0] IDX_WHEEL  = 2'd3;

   // header byte bit positions
   localparam int HDR_LEFT   = 0;
   localparam int HDR_RIGHT  = 1;
   localparam int HDR_MIDDLE = 2;
   localparam int HDR_SIGN_X = 4;
   localparam int HDR_SIGN_Y = 5;
   localparam int HDR_OVF_X  = 6;
   localparam int HDR_OVF_Y  = 7;

   // report layout, last member lowest: btn_left sits in bit 0
   typedef struct packed {
      logic [RSP_PAD_W-1:0]      pad;
      logic signed [POS_W-1:0]   pos_z;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_x;
      logic                      overflow_y;
      logic                      overflow_x;
      logic signed [WHEEL_W-1:0] delta_z;
      logic signed [DELTA_W-1:0] delta_y;
      logic signed [DELTA_W-1:0] delta_x;
      logic [EXTRA_W-1:0]        extra_buttons;
      logic                      btn_middle;
      logic                      btn_right;
      logic                      btn_left;
   } rsp_data_type;

   localparam int RSP_DATA_W = $bits(rsp_data_type);

endpackage

[design/mouse_packet_decoder.sv]
// ---------------------------------------------------------------------------
// mouse_packet_decoder - mouse byte framing and position tracking
// Frames received mouse bytes into 3- or 4-byte packets, decodes buttons,
// overflow flags and deltas, and keeps wrapping X/Y/Z positions.
// ---------------------------------------------------------------------------
// One received byte is taken per clock on the req_ stream. Bytes that do not
// close a packet are always taken at once; the closing byte of a packet is
// decoded and added into the positions in the same cycle and its report
// appears on the rsp_ stream from the next cycle. The only stall is the
// report register: a closing byte waits while a previous report is held and
// rsp_tready is low. Sustained rate is therefore one byte per cycle. The
// packet format is read from the csr_ register on every byte, so it should be
// changed only between packets. There is no header resynchronisation.
// ---------------------------------------------------------------------------
module mouse_packet_decoder (
   input  logic                            clock,
   input  logic                            reset,
   // configuration: packet_format
   input  logic                            csr_wr_en,
   input  logic [mpd_pkg::FORMAT_W-1:0]    csr_wr_data,
   // req_tdata: rx_byte[7:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mpd_pkg::BYTE_W-1:0]      req_tdata,
   // rsp_tdata, from bit 0: btn_left, btn_right, btn_middle, extra_buttons[2],
   // delta_x[9], delta_y[9], delta_z[8], overflow_x, overflow_y, pos_x[32],
   // pos_y[32], pos_z[32], zero pad[7]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mpd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import mpd_pkg::*;

   logic [FORMAT_W-1:0] format_ff;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0]   header_ff, x_ff, y_ff;
   logic [POS_W-1:0]    acc_x_ff, acc_y_ff, acc_z_ff;
   logic [POS_W-1:0]    acc_x_in, acc_y_in, acc_z_in;
   rsp_data_type        rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic                accept;
   logic                last_byte;
   logic [BYTE_W-1:0]   y_byte;
   logic [DELTA_W-1:0]  dx, dy;
   logic [WHEEL_W-1:0]  dz;
   logic [EXTRA_W-1:0]  extra;

   assign last_byte = (index_ff == IDX_WHEEL) ||
                      (index_ff == IDX_Y && format_ff == FMT_STANDARD);

   // a closing byte needs room in the report register
   assign req_tready = !last_byte || !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign index_in = last_byte ? IDX_HEADER : index_ff + INDEX_W'(1);

   // in the standard format the Y byte arrives with the closing transaction
   assign y_byte = (index_ff == IDX_Y) ? req_tdata : y_ff;

   assign dx = {header_ff[HDR_SIGN_X], x_ff};
   assign dy = {header_ff[HDR_SIGN_Y], y_byte};

   always_comb begin
      dz    = '0;
      extra = '0;
      if (index_ff == IDX_WHEEL) begin
         unique case (format_ff)
            FMT_STANDARD: begin
               dz = '0;
            end
            FMT_EXTENDED: begin
               dz    = {{(WHEEL_W-4){req_tdata[3]}}, req_tdata[3:0]};
               extra = req_tdata[5:4];
            end
            default: begin
               dz = req_tdata;
            end
         endcase
      end
   end

   assign acc_x_in = acc_x_ff + {{(POS_W-DELTA_W){dx[DELTA_W-1]}}, dx};
   assign acc_y_in = acc_y_ff + {{(POS_W-DELTA_W){dy[DELTA_W-1]}}, dy};
   assign acc_z_in = acc_z_ff + {{(POS_W-WHEEL_W){dz[WHEEL_W-1]}}, dz};

   always_comb begin
      rsp_in               = '0;
      rsp_in.btn_left      = header_ff[HDR_LEFT];
      rsp_in.btn_right     = header_ff[HDR_RIGHT];
      rsp_in.btn_middle    = header_ff[HDR_MIDDLE];
      rsp_in.extra_buttons = extra;
      rsp_in.delta_x       = dx;
      rsp_in.delta_y       = dy;
      rsp_in.delta_z       = dz;
      rsp_in.overflow_x    = header_ff[HDR_OVF_X];
      rsp_in.overflow_y    = header_ff[HDR_OVF_Y];
      rsp_in.pos_x         = acc_x_in;
      rsp_in.pos_y         = acc_y_in;
      rsp_in.pos_z         = acc_z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_RESET;
         index_ff     <= IDX_HEADER;
         header_ff    <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            format_ff <= csr_wr_data;
         end
         // a new report may replace the one leaving in the same cycle
         if (accept && last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            index_ff <= index_in;
            unique case (index_ff)
               IDX_HEADER: header_ff <= req_tdata;
               IDX_X:      x_ff      <= req_tdata;
               IDX_Y:      y_ff      <= req_tdata;
               default:    ;
            endcase
            if (last_byte) begin
               acc_x_ff     <= acc_x_in;
               acc_y_ff     <= acc_y_in;
               acc_z_ff     <= acc_z_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule
